// ===== hw/rtl/rmrt_pkg.sv =====
// Package: constants, types and state codes for the response-time block
package rmrt_pkg;

    localparam int TASK_CAPACITY = 16;
    localparam int ITERATION_CAP = 64;
    localparam int TIME_BITS     = 32;

    localparam int IDX_BITS  = $clog2(TASK_CAPACITY);
    localparam int CNT_BITS  = $clog2(TASK_CAPACITY + 1);
    localparam int ITER_BITS = $clog2(ITERATION_CAP + 1);
    localparam int DCNT_BITS = $clog2(TIME_BITS + 1);

    typedef logic [TIME_BITS-1:0] t_time;

    localparam t_time TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct packed {
        t_time period;
        t_time exec;
        t_time deadline;
    } t_task;

    typedef struct packed {
        logic  done;
        t_time quot;
        logic  rem_nz;
    } t_div_res;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SRD,
        S_SCMP,
        S_SW1,
        S_SW2,
        S_SADV,
        S_ARD,
        S_AINIT,
        S_ISTART,
        S_IRD,
        S_DIVGO,
        S_DIV,
        S_MUL,
        S_ADD,
        S_CHECK,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/rmrt_if.sv =====
// Interfaces: task input channel and result output channel
interface rmrt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] task_period;
    logic [31:0] exec_time;
    logic [31:0] task_deadline;
    logic        last_task;

    modport source (output valid, task_period, exec_time, task_deadline, last_task,
                    input ready);
    modport sink (input valid, task_period, exec_time, task_deadline, last_task,
                  output ready);
endinterface

interface rmrt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  sorted_position;
    logic [31:0] period_of_task;
    logic [31:0] response_time;
    logic        fixed_point_reached;
    logic        meets_deadline;
    logic        set_schedulable;
    logic        tasks_dropped;
    logic        last_result;

    modport source (output valid, sorted_position, period_of_task, response_time,
                    fixed_point_reached, meets_deadline, set_schedulable,
                    tasks_dropped, last_result,
                    input ready);
    modport sink (input valid, sorted_position, period_of_task, response_time,
                  fixed_point_reached, meets_deadline, set_schedulable,
                  tasks_dropped, last_result,
                  output ready);
endinterface

// ===== hw/rtl/rate_monotonic_response_time.sv =====
// Top level: task load, exchange sort and response-time iteration
//
//  channel  | dir | handshake     | word
//  i_task   | in  | valid/ready   | period, exec time, deadline, last flag
//  o_res    | out | valid/ready   | position, period, response, flags, last
//
// Loading accepts a task whenever valid is high; ready stays low from the last
// task until the last result is taken. Sort: each compared pair is read, compared
// and advanced, with two write steps more when the pair swaps, n(n-1)/2 pairs.
// Analysis: one serial divider pass per higher-priority task per iteration, up to
// 64 iterations per task. Results wait for o_res.ready.
// Synchronous reset clears the sequencer, task count and drop flag.
module rate_monotonic_response_time
    import rmrt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmrt_in_if.sink    i_task,
    rmrt_out_if.source o_res
);

    t_task r_mem [TASK_CAPACITY];
    t_task r_rda;
    t_task r_rdb;

    t_state r_state;
    t_state n_state;

    logic [CNT_BITS-1:0]  r_count;
    logic                 r_ovf;
    logic [CNT_BITS-1:0]  r_i;
    logic [CNT_BITS-1:0]  r_j;
    logic [ITER_BITS-1:0] r_iter;
    t_time                r_r;
    t_time                r_rn;
    t_time                r_q;
    logic [2*TIME_BITS-1:0] r_prod;
    logic                 r_conv;
    logic                 r_allok;

    logic                 we;
    logic [IDX_BITS-1:0]  waddr;
    t_task                wdata;
    logic                 rea;
    logic                 reb;
    logic [IDX_BITS-1:0]  addra;
    logic [IDX_BITS-1:0]  addrb;
    logic                 div_start;
    t_div_res             div_res;
    t_time                divisor;

    logic                 in_acc;
    logic                 out_acc;
    logic                 is_last;
    logic                 meets;
    t_time                sat_prod;
    logic [TIME_BITS:0]   sum;

    assign in_acc   = i_task.valid && i_task.ready;
    assign out_acc  = o_res.valid && o_res.ready;
    assign is_last  = (r_i + 1'b1) == r_count;
    assign meets    = r_conv && (r_r <= r_rda.deadline);
    assign divisor  = (r_rdb.period == '0) ? t_time'(1) : r_rdb.period;
    assign sat_prod = (|r_prod[2*TIME_BITS-1:TIME_BITS]) ? TIME_MAX
                                                         : r_prod[TIME_BITS-1:0];
    assign sum      = {1'b0, r_rn} + {1'b0, sat_prod};

    rmrt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_r),
        .i_divisor  (divisor),
        .o_res      (div_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && i_task.last_task) begin
                    n_state = (r_count == CNT_BITS'(0)) ? S_ARD : S_SRD;
                end
            end
            S_SRD:  n_state = S_SCMP;
            S_SCMP: n_state = (r_rdb.period < r_rda.period) ? S_SW1 : S_SADV;
            S_SW1:  n_state = S_SW2;
            S_SW2:  n_state = S_SADV;
            S_SADV: begin
                if ((r_j + 1'b1) < r_count || (r_i + 2'd2) < r_count) begin
                    n_state = S_SRD;
                end else begin
                    n_state = S_ARD;
                end
            end
            S_ARD:    n_state = S_AINIT;
            S_AINIT:  n_state = S_ISTART;
            S_ISTART: n_state = (r_i == '0) ? S_CHECK : S_IRD;
            S_IRD:    n_state = S_DIVGO;
            S_DIVGO:  n_state = S_DIV;
            S_DIV:    n_state = div_res.done ? S_MUL : S_DIV;
            S_MUL:    n_state = S_ADD;
            S_ADD:    n_state = ((r_j + 1'b1) == r_i) ? S_CHECK : S_IRD;
            S_CHECK: begin
                if (r_rn == r_r || r_rn > r_rda.deadline ||
                    (r_iter + 1'b1) == ITER_BITS'(ITERATION_CAP)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ISTART;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    n_state = is_last ? S_LOAD : S_ARD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        we        = 1'b0;
        waddr     = r_count[IDX_BITS-1:0];
        wdata     = '{period:   TIME_BITS'(i_task.task_period),
                      exec:     TIME_BITS'(i_task.exec_time),
                      deadline: TIME_BITS'(i_task.task_deadline)};
        rea       = 1'b0;
        reb       = 1'b0;
        addra     = r_i[IDX_BITS-1:0];
        addrb     = r_j[IDX_BITS-1:0];
        div_start = 1'b0;
        unique case (r_state)
            S_LOAD:  we = in_acc && (r_count < CNT_BITS'(TASK_CAPACITY));
            S_SRD: begin
                rea = 1'b1;
                reb = 1'b1;
            end
            S_SW1: begin
                we    = 1'b1;
                waddr = r_i[IDX_BITS-1:0];
                wdata = r_rdb;
            end
            S_SW2: begin
                we    = 1'b1;
                waddr = r_j[IDX_BITS-1:0];
                wdata = r_rda;
            end
            S_ARD:   rea = 1'b1;
            S_IRD:   reb = 1'b1;
            S_DIVGO: div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rea) begin
            r_rda <= r_mem[addra];
        end
        if (reb) begin
            r_rdb <= r_mem[addrb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_allok <= 1'b1;
            r_i     <= '0;
            r_j     <= '0;
            r_iter  <= '0;
            r_conv  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_count < CNT_BITS'(TASK_CAPACITY)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    r_i <= '0;
                    r_j <= CNT_BITS'(1);
                end
                S_SADV: begin
                    if ((r_j + 1'b1) < r_count) begin
                        r_j <= r_j + 1'b1;
                    end else if ((r_i + 2'd2) < r_count) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + 2'd2;
                    end else begin
                        r_i <= '0;
                    end
                end
                S_AINIT: begin
                    r_r    <= r_rda.exec;
                    r_iter <= '0;
                end
                S_ISTART: begin
                    r_rn <= r_rda.exec;
                    r_j  <= '0;
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_q <= div_res.quot + t_time'(div_res.rem_nz);
                    end
                end
                S_MUL: r_prod <= r_q * r_rdb.exec;
                S_ADD: begin
                    r_rn <= sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
                    r_j  <= r_j + 1'b1;
                end
                S_CHECK: begin
                    r_conv <= (r_rn == r_r);
                    if (r_rn != r_r && r_rn <= r_rda.deadline) begin
                        r_r    <= r_rn;
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_i <= r_i + 1'b1;
                        if (is_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_allok <= 1'b1;
                        end else begin
                            r_allok <= r_allok && meets;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_task.ready              = (r_state == S_LOAD);
    assign o_res.valid               = (r_state == S_OUT);
    assign o_res.sorted_position     = 4'(r_i);
    assign o_res.period_of_task      = 32'(r_rda.period);
    assign o_res.response_time       = 32'(r_r);
    assign o_res.fixed_point_reached = r_conv;
    assign o_res.meets_deadline      = meets;
    assign o_res.set_schedulable     = r_allok && meets;
    assign o_res.tasks_dropped       = r_ovf;
    assign o_res.last_result         = is_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_task.ready && o_res.valid))
        else $error("input ready while a result is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(TASK_CAPACITY))
        else $error("task count above capacity");

    a_res_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_count != '0) && (r_i < r_count))
        else $error("result without a stored task");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

endmodule

// ===== hw/rtl/rmrt_div.sv =====
// Restoring divider, one quotient bit per cycle
module rmrt_div
    import rmrt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_time    i_dividend,
    input  t_time    i_divisor,
    output t_div_res o_res
);

    logic [TIME_BITS:0]   r_rem;
    t_time                r_quo;
    logic [DCNT_BITS-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    t_time                r_dvs;

    logic [TIME_BITS:0] shifted;
    logic [TIME_BITS:0] diff;

    assign shifted = {r_rem[TIME_BITS-1:0], r_quo[TIME_BITS-1]};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_BITS'(TIME_BITS);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (shifted >= {1'b0, r_dvs}) begin
                    r_rem <= diff;
                    r_quo <= {r_quo[TIME_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_quo <= {r_quo[TIME_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.quot   = r_quo;
    assign o_res.rem_nz = |r_rem;

endmodule

// ===== sim/tb_rmrt_if.sv =====
// Testbench interface copies are not needed; this file holds the stimulus and expected-result record types
`timescale 1ns / 100ps
package tb_rmrt_types;

    typedef struct {
        logic [31:0] period;
        logic [31:0] exec;
        logic [31:0] deadline;
        logic        last;
        logic        chk;
        logic [3:0]  pos;
        logic [31:0] rsp;
        logic        conv;
        logic        meets;
    } t_row;

    typedef struct {
        logic [3:0]  pos;
        logic [31:0] period;
        logic [31:0] rsp;
        logic        conv;
        logic        meets;
        logic        sched;
        logic        dropped;
        logic        last;
    } t_res;

endpackage

// ===== sim/tb_top.sv =====
// Testbench top: drives task sets, predicts response times and checks each result word
`timescale 1ns / 100ps
module tb_top;
    import rmrt_pkg::*;
    import tb_rmrt_types::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rmrt_in_if  task_ch ();
    rmrt_out_if res_ch ();

    rate_monotonic_response_time dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (task_ch.sink),
        .o_res   (res_ch.source)
    );

    always #4 i_clk = ~i_clk;

    t_time  set_per [$];
    t_time  set_exe [$];
    t_time  set_dl  [$];
    logic   set_drop;
    t_res   expected_q [$];
    int     errors = 0;
    int     send_idle = 0;
    int     recv_idle = 0;
    logic   recv_hold = 1'b0;
    logic   sending_done = 1'b0;
    t_row   rows [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic t_time sadd(t_time a, t_time b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TIME_MAX : s[31:0];
    endfunction

    function automatic t_time smul(t_time a, t_time b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return (p[63:32] != 0) ? TIME_MAX : p[31:0];
    endfunction

    function automatic t_time cdiv(t_time r, t_time t);
        t_time q;
        if (t == 0) t = 1;
        q = r / t;
        if (r % t != 0) q++;
        return q;
    endfunction

    task automatic predict_set();
        t_time sp [$];
        t_time sc [$];
        t_time sd [$];
        t_time tmp;
        t_time r;
        t_time rn;
        logic  conv;
        logic  ok;
        int    n;
        t_res  e;
        sp = set_per; sc = set_exe; sd = set_dl;
        n = sp.size();
        ok = 1'b1;
        for (int i = 0; i + 1 < n; i++)
            for (int j = i + 1; j < n; j++)
                if (sp[j] < sp[i]) begin
                    tmp = sp[i]; sp[i] = sp[j]; sp[j] = tmp;
                    tmp = sc[i]; sc[i] = sc[j]; sc[j] = tmp;
                    tmp = sd[i]; sd[i] = sd[j]; sd[j] = tmp;
                end
        for (int i = 0; i < n; i++) begin
            r = sc[i];
            conv = 1'b0;
            for (int it = 0; it < ITERATION_CAP; it++) begin
                rn = sc[i];
                for (int j = 0; j < i; j++) rn = sadd(rn, smul(cdiv(r, sp[j]), sc[j]));
                if (rn == r) begin
                    conv = 1'b1;
                    break;
                end
                if (rn > sd[i]) break;
                r = rn;
            end
            e.pos = i[3:0];
            e.period = sp[i];
            e.rsp = r;
            e.conv = conv;
            e.meets = conv && (r <= sd[i]);
            if (!e.meets) ok = 1'b0;
            e.sched = ok;
            e.dropped = set_drop;
            e.last = (i + 1 == n);
            expected_q.push_back(e);
        end
        set_per.delete(); set_exe.delete(); set_dl.delete();
        set_drop = 1'b0;
    endtask

    task automatic absorb_word(input t_row w);
        if (set_per.size() < TASK_CAPACITY) begin
            set_per.push_back(w.period);
            set_exe.push_back(w.exec);
            set_dl.push_back(w.deadline);
        end else begin
            set_drop = 1'b1;
        end
        if (w.last) predict_set();
    endtask

    task automatic send_word(input t_row w);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            task_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        task_ch.valid         <= 1'b1;
        task_ch.task_period   <= w.period;
        task_ch.exec_time     <= w.exec;
        task_ch.task_deadline <= w.deadline;
        task_ch.last_task     <= w.last;
        @(posedge i_clk);
        while (!task_ch.ready) @(posedge i_clk);
        absorb_word(w);
    endtask

    function automatic t_row mk(t_time p, t_time c, t_time d, logic l);
        t_row w;
        w.period = p; w.exec = c; w.deadline = d; w.last = l;
        w.chk = 1'b0; w.pos = 0; w.rsp = 0; w.conv = 0; w.meets = 0;
        return w;
    endfunction

    function automatic t_time rnd_time(int kind);
        case (kind)
            0: return t_time'($urandom_range(1, 20));
            1: return t_time'($urandom_range(1, 400));
            2: return t_time'($urandom);
            default: return TIME_MAX - t_time'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic send_random_set(input int tasks);
        t_row w;
        int k;
        k = $urandom_range(0, 9) < 8 ? $urandom_range(0, 1) : $urandom_range(2, 3);
        for (int i = 0; i < tasks; i++) begin
            w = mk(rnd_time(k), rnd_time(k), rnd_time(k), i == tasks - 1);
            if ($urandom_range(0, 3) == 0) begin
                w.exec = 32'($urandom_range(0, 3));
                w.deadline = 32'(w.period * 32'($urandom_range(1, 4)));
            end
            if ($urandom_range(0, 19) == 0) w.period = 0;
            send_word(w);
        end
    endtask

    task automatic drain();
        task_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (recv_hold) res_ch.ready <= 1'b0;
            else res_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", res_ch.period_of_task, 0);
            end else begin
                e = expected_q.pop_front();
                if (res_ch.sorted_position !== e.pos)
                    report_mismatch("position", res_ch.sorted_position, e.pos);
                if (res_ch.period_of_task !== e.period)
                    report_mismatch("period", res_ch.period_of_task, e.period);
                if (res_ch.response_time !== e.rsp)
                    report_mismatch("response", res_ch.response_time, e.rsp);
                if (res_ch.fixed_point_reached !== e.conv)
                    report_mismatch("converged", res_ch.fixed_point_reached, e.conv);
                if (res_ch.meets_deadline !== e.meets)
                    report_mismatch("meets", res_ch.meets_deadline, e.meets);
                if (res_ch.set_schedulable !== e.sched)
                    report_mismatch("schedulable", res_ch.set_schedulable, e.sched);
                if (res_ch.tasks_dropped !== e.dropped)
                    report_mismatch("dropped", res_ch.tasks_dropped, e.dropped);
                if (res_ch.last_result !== e.last)
                    report_mismatch("last", res_ch.last_result, e.last);
            end
        end
    end

    initial begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_row w;
        t_res e;
        int n;
        set_drop = 1'b0;
        task_ch.valid = 1'b0;
        task_ch.task_period = '0;
        task_ch.exec_time = '0;
        task_ch.task_deadline = '0;
        task_ch.last_task = 1'b0;
        res_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        w = mk(10, 3, 10, 1); w.chk = 1; w.pos = 0; w.rsp = 3; w.conv = 1; w.meets = 1;
        rows.push_back(w);
        w = mk(TIME_MAX, TIME_MAX, TIME_MAX, 1); w.chk = 1; w.pos = 0; w.rsp = TIME_MAX;
        w.conv = 1; w.meets = 1;
        rows.push_back(w);
        w = mk(5, 0, 0, 1); w.chk = 1; w.pos = 0; w.rsp = 0; w.conv = 1; w.meets = 1;
        rows.push_back(w);
        w = mk(5, 7, 3, 1); w.chk = 1; w.pos = 0; w.rsp = 7; w.conv = 1; w.meets = 0;
        rows.push_back(w);
        rows.push_back(mk(8, 2, 8, 0));
        rows.push_back(mk(4, 1, 4, 0));
        rows.push_back(mk(4, 1, 4, 0));
        rows.push_back(mk(0, 1, 9, 0));
        rows.push_back(mk(20, 5, 20, 1));
        rows.push_back(mk(3, 2, 3, 0));
        rows.push_back(mk(5, 2, 5, 1));
        rows.push_back(mk(TIME_MAX, TIME_MAX, 0, 0));
        rows.push_back(mk(TIME_MAX, TIME_MAX, TIME_MAX, 1));
        rows.push_back(mk(1, 1, 1, 0));
        rows.push_back(mk(1000, 0, TIME_MAX, 1));
        for (int i = 0; i < 17; i++)
            rows.push_back(mk(100 - i, i[0], 400, i == 16));

        foreach (rows[i]) begin
            send_word(rows[i]);
            if (rows[i].chk) begin
                e = expected_q[0];
                if (e.pos !== rows[i].pos || e.rsp !== rows[i].rsp ||
                    e.conv !== rows[i].conv || e.meets !== rows[i].meets)
                    report_mismatch("typed row", e.rsp, rows[i].rsp);
                expected_q[0].pos = rows[i].pos;
                expected_q[0].rsp = rows[i].rsp;
                expected_q[0].conv = rows[i].conv;
                expected_q[0].meets = rows[i].meets;
            end
        end
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 36 : (ph == 1) ? 73 : 0;
            recv_idle = (ph == 0) ? 73 : (ph == 1) ? 36 : 0;
            n = 0;
            while (n < 95) begin
                int t;
                t = $urandom_range(0, 9) == 0 ? $urandom_range(17, 19) : $urandom_range(1, 5);
                send_random_set(t);
                n += t;
            end
            drain();
        end

        fork
            begin
                recv_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            begin
                send_random_set(4);
                send_random_set(3);
            end
        join
        drain();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
